[src/ygd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ygd_pkg
// Shared types, register codes and the sigmoid table of the grid decoder.
// ----------------------------------------------------------------------------
package ygd_pkg;

    localparam int CFG_DATA_W = 27;
    localparam int CFG_IDX_W  = 3;
    localparam int OUT_DATA_W = 104;
    localparam int Q_DEPTH    = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ZERO_POINT,
        CFG_SCALE_Q,
        CFG_GRID_WIDTH,
        CFG_GRID_HEIGHT,
        CFG_CELL_STRIDE,
        CFG_ANCHOR_WIDTHS,
        CFG_ANCHOR_HEIGHTS,
        CFG_RAW_THRESHOLD
    } t_cfg_idx;

    localparam logic [7:0]  RST_ZERO_POINT     = 8'h00;
    localparam logic [15:0] RST_SCALE_Q        = 16'd4096;
    localparam logic [7:0]  RST_GRID_WIDTH     = 8'd80;
    localparam logic [7:0]  RST_GRID_HEIGHT    = 8'd80;
    localparam logic [6:0]  RST_CELL_STRIDE    = 7'd8;
    localparam logic [26:0] RST_ANCHOR_WIDTHS  = 27'd8658954;
    localparam logic [26:0] RST_ANCHOR_HEIGHTS = 27'd6044685;
    localparam logic [7:0]  RST_RAW_THRESHOLD  = 8'h80;

    // objectness * class probability must reach 0.25 in Q0.16
    localparam logic [15:0] SCORE_MIN = 16'd16384;

    typedef struct packed {
        logic signed [7:0] zero_point;
        logic [15:0]       scale_q;
        logic [7:0]        grid_width;
        logic [7:0]        grid_height;
        logic [6:0]        cell_stride;
        logic [26:0]       anchor_widths;
        logic [26:0]       anchor_heights;
        logic signed [7:0] raw_threshold;
    } t_cfg;

    typedef struct packed {
        logic [15:0] sx;
        logic [15:0] sy;
        logic [15:0] sw;
        logic [15:0] sh;
        logic [6:0]  col;
        logic [6:0]  row;
        logic [1:0]  anchor;
        logic [15:0] score;
        logic [6:0]  cls;
    } t_box_job;

    typedef struct packed {
        logic     push;
        t_box_job job;
    } t_q_push;

    typedef struct packed {
        logic not_empty;
        logic has_room;
    } t_q_status;

    // round(65536*sigmoid(k/4)); anything at or past 32 saturates to the last entry
    function automatic logic [15:0] sig_rom(input logic [5:0] idx);
        logic [15:0] v;
        case (idx)
            6'd0:    v = 16'd32768;
            6'd1:    v = 16'd36843;
            6'd2:    v = 16'd40793;
            6'd3:    v = 16'd44511;
            6'd4:    v = 16'd47911;
            6'd5:    v = 16'd50941;
            6'd6:    v = 16'd53581;
            6'd7:    v = 16'd55834;
            6'd8:    v = 16'd57724;
            6'd9:    v = 16'd59287;
            6'd10:   v = 16'd60565;
            6'd11:   v = 16'd61598;
            6'd12:   v = 16'd62428;
            6'd13:   v = 16'd63090;
            6'd14:   v = 16'd63615;
            6'd15:   v = 16'd64030;
            6'd16:   v = 16'd64357;
            6'd17:   v = 16'd64614;
            6'd18:   v = 16'd64816;
            6'd19:   v = 16'd64974;
            6'd20:   v = 16'd65097;
            6'd21:   v = 16'd65194;
            6'd22:   v = 16'd65269;
            6'd23:   v = 16'd65328;
            6'd24:   v = 16'd65374;
            6'd25:   v = 16'd65410;
            6'd26:   v = 16'd65438;
            6'd27:   v = 16'd65459;
            6'd28:   v = 16'd65476;
            6'd29:   v = 16'd65489;
            6'd30:   v = 16'd65500;
            6'd31:   v = 16'd65508;
            default: v = 16'd65514;
        endcase
        return v;
    endfunction

endpackage

[src/yolo_grid_decode_nhwc_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// yolo_grid_decode_nhwc_unit
// Decodes one int8 NHWC head tensor into scored boxes.
// ----------------------------------------------------------------------------
// Usage:
//  s_axis carries one tensor element per transfer (tdata = elem_value);
//  tuser high marks the first element of a tensor and restarts the position.
//  Elements run row, column, anchor, channel, 5 + CLASS_COUNT per vector.
//  m_axis carries at most one box per vector, in input order.
//  Configuration registers are written through i_cfg_we/addr/data while the
//  stream is idle; writes take effect at the next edge.
//  Throughput: one element per cycle. s_axis_tready drops only while the
//  box queue has fewer than two free entries; the geometry unit steps through
//  five states per box (its multiply sequence), fewer than the elements of
//  one vector, so it keeps up.
//  When m_axis stalls, the finished box waits in the output register, the
//  geometry unit finishes the next box, and the queue absorbs further boxes;
//  intake stops once the queue is close to full.
//  Reset (synchronous, active low) restores the register defaults and
//  restarts at row 0, column 0, anchor 0, channel 0, empty queue.
// ----------------------------------------------------------------------------
module yolo_grid_decode_nhwc_unit #(
    parameter int CLASS_COUNT      = 1,
    parameter int ANCHORS_PER_CELL = 3,
    parameter int GRID_MAX         = 128
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [7:0] elem_value
    input  logic [7:0]                         s_axis_tdata,
    // [0] tensor_start
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [15:0] left_x, [31:16] top_y, [47:32] right_x, [63:48] bottom_y,
    // [79:64] box_score, [86:80] class_index, [93:87] cell_row,
    // [100:94] cell_col, [102:101] anchor_slot, [103] zero
    output logic [ygd_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    input  logic                               i_cfg_we,
    input  logic [ygd_pkg::CFG_IDX_W-1:0]      i_cfg_addr,
    input  logic [ygd_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    import ygd_pkg::*;

    t_cfg      r_cfg;
    t_q_push   w_q_push;
    t_q_status w_q_status;
    t_box_job  w_q_job;
    logic      w_q_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.zero_point     <= RST_ZERO_POINT;
            r_cfg.scale_q        <= RST_SCALE_Q;
            r_cfg.grid_width     <= RST_GRID_WIDTH;
            r_cfg.grid_height    <= RST_GRID_HEIGHT;
            r_cfg.cell_stride    <= RST_CELL_STRIDE;
            r_cfg.anchor_widths  <= RST_ANCHOR_WIDTHS;
            r_cfg.anchor_heights <= RST_ANCHOR_HEIGHTS;
            r_cfg.raw_threshold  <= RST_RAW_THRESHOLD;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_ZERO_POINT:     r_cfg.zero_point     <= i_cfg_data[7:0];
                CFG_SCALE_Q:        r_cfg.scale_q        <= i_cfg_data[15:0];
                CFG_GRID_WIDTH:     r_cfg.grid_width     <= i_cfg_data[7:0];
                CFG_GRID_HEIGHT:    r_cfg.grid_height    <= i_cfg_data[7:0];
                CFG_CELL_STRIDE:    r_cfg.cell_stride    <= i_cfg_data[6:0];
                CFG_ANCHOR_WIDTHS:  r_cfg.anchor_widths  <= i_cfg_data[26:0];
                CFG_ANCHOR_HEIGHTS: r_cfg.anchor_heights <= i_cfg_data[26:0];
                CFG_RAW_THRESHOLD:  r_cfg.raw_threshold  <= i_cfg_data[7:0];
                default:            r_cfg                <= r_cfg;
            endcase
        end
    end

    ygd_front #(
        .CLASS_COUNT      (CLASS_COUNT),
        .ANCHORS_PER_CELL (ANCHORS_PER_CELL),
        .GRID_MAX         (GRID_MAX)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_in_valid     (s_axis_tvalid),
        .o_in_ready     (s_axis_tready),
        .i_elem_value   ($signed(s_axis_tdata)),
        .i_tensor_start (s_axis_tuser),
        .i_q_status     (w_q_status),
        .o_q_push       (w_q_push)
    );

    ygd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_q_push),
        .i_pop    (w_q_pop),
        .o_status (w_q_status),
        .o_job    (w_q_job)
    );

    ygd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_status  (w_q_status),
        .i_q_job     (w_q_job),
        .o_q_pop     (w_q_pop),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

endmodule

[src/ygd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ygd_front
// Element intake: position tracking, dequantization, sigmoid, class maximum
// and score test. Pushes one box job per qualifying anchor vector.
// ----------------------------------------------------------------------------
module ygd_front #(
    parameter int CLASS_COUNT      = 1,
    parameter int ANCHORS_PER_CELL = 3,
    parameter int GRID_MAX         = 128
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ygd_pkg::t_cfg      i_cfg,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [7:0]  i_elem_value,
    input  logic               i_tensor_start,
    input  ygd_pkg::t_q_status i_q_status,
    output ygd_pkg::t_q_push   o_q_push
);
    import ygd_pkg::*;

    localparam int VEC_LEN = 5 + CLASS_COUNT;
    localparam int CH_W    = $clog2(VEC_LEN);
    localparam int POS_W   = $clog2(GRID_MAX);
    localparam int DIM_W   = POS_W + 1;

    typedef enum logic [1:0] {
        KIND_BOX,
        KIND_OBJ,
        KIND_CLS_FIRST,
        KIND_CLS
    } t_kind;

    // position counters
    logic [CH_W-1:0]  r_chan;
    logic [1:0]       r_anchor;
    logic [POS_W-1:0] r_col;
    logic [POS_W-1:0] r_row;

    // stage A: dequantized value
    logic                    r_a_valid;
    logic signed [17:0]      r_a_d;
    t_kind                   r_a_kind;
    logic [1:0]              r_a_box_idx;
    logic [6:0]              r_a_cls;
    logic                    r_a_last;
    logic                    r_a_below;
    logic [1:0]              r_a_anchor;
    logic [POS_W-1:0]        r_a_col;
    logic [POS_W-1:0]        r_a_row;

    // stage B: sigmoid value
    logic                    r_b_valid;
    logic [15:0]             r_b_sig;
    t_kind                   r_b_kind;
    logic [1:0]              r_b_box_idx;
    logic [6:0]              r_b_cls;
    logic                    r_b_last;
    logic                    r_b_below;
    logic [1:0]              r_b_anchor;
    logic [POS_W-1:0]        r_b_col;
    logic [POS_W-1:0]        r_b_row;

    // per-vector accumulation
    logic [15:0]             r_box [4];
    logic [15:0]             r_obj;
    logic [15:0]             r_best;
    logic [6:0]              r_best_cls;
    logic                    r_skip;

    // stage C: finished vector, score test
    logic                    r_c_valid;
    logic [15:0]             r_c_box [4];
    logic [15:0]             r_c_obj;
    logic [15:0]             r_c_best;
    logic [6:0]              r_c_cls;
    logic                    r_c_skip;
    logic [1:0]              r_c_anchor;
    logic [POS_W-1:0]        r_c_col;
    logic [POS_W-1:0]        r_c_row;

    logic                    w_accept;
    logic [CH_W-1:0]         w_chan;
    logic [1:0]              w_anchor;
    logic [POS_W-1:0]        w_col;
    logic [POS_W-1:0]        w_row;
    logic                    w_last;
    t_kind                   w_kind;
    logic [DIM_W-1:0]        w_eff_w;
    logic [DIM_W-1:0]        w_eff_h;
    logic [1:0]              w_anchor_inc;
    logic [DIM_W-1:0]        w_col_inc;
    logic [DIM_W-1:0]        w_row_inc;
    logic [CH_W-1:0]         n_chan;
    logic [1:0]              n_anchor;
    logic [POS_W-1:0]        n_col;
    logic [POS_W-1:0]        n_row;
    logic signed [8:0]       w_diff;
    logic signed [25:0]      w_prod;
    logic signed [17:0]      w_d;

    logic [17:0]             w_abs;
    logic [7:0]              w_idx;
    logic [9:0]              w_frac;
    logic [15:0]             w_lo;
    logic [15:0]             w_hi;
    logic [25:0]             w_interp;
    logic [15:0]             w_p;
    logic [16:0]             w_neg;
    logic [15:0]             w_sig;

    logic [15:0]             n_best;
    logic [6:0]              n_best_cls;
    logic [31:0]             w_score_full;
    logic [15:0]             w_score;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [7:0] r);
        logic [DIM_W-1:0] v;
        if (r == 8'd0) begin
            v = DIM_W'(1);
        end else if (r > 8'(GRID_MAX)) begin
            v = DIM_W'(GRID_MAX);
        end else begin
            v = DIM_W'(r);
        end
        return v;
    endfunction

    // at most one vector end is in flight, so two free entries always suffice
    assign o_in_ready = i_q_status.has_room;
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_chan   = i_tensor_start ? '0 : r_chan;
    assign w_anchor = i_tensor_start ? '0 : r_anchor;
    assign w_col    = i_tensor_start ? '0 : r_col;
    assign w_row    = i_tensor_start ? '0 : r_row;
    assign w_last   = (w_chan == CH_W'(VEC_LEN - 1));

    always_comb begin
        if (w_chan < CH_W'(4)) begin
            w_kind = KIND_BOX;
        end else if (w_chan == CH_W'(4)) begin
            w_kind = KIND_OBJ;
        end else if (w_chan == CH_W'(5)) begin
            w_kind = KIND_CLS_FIRST;
        end else begin
            w_kind = KIND_CLS;
        end
    end

    assign w_eff_w      = eff_dim(i_cfg.grid_width);
    assign w_eff_h      = eff_dim(i_cfg.grid_height);
    assign w_anchor_inc = w_anchor + 2'd1;
    assign w_col_inc    = DIM_W'(w_col) + DIM_W'(1);
    assign w_row_inc    = DIM_W'(w_row) + DIM_W'(1);

    always_comb begin
        n_chan   = w_chan + CH_W'(1);
        n_anchor = w_anchor;
        n_col    = w_col;
        n_row    = w_row;
        if (w_last) begin
            n_chan = '0;
            if (w_anchor_inc >= 2'(ANCHORS_PER_CELL)) begin
                n_anchor = '0;
                if (w_col_inc >= w_eff_w) begin
                    n_col = '0;
                    if (w_row_inc >= w_eff_h) begin
                        n_row = '0;
                    end else begin
                        n_row = w_row_inc[POS_W-1:0];
                    end
                end else begin
                    n_col = w_col_inc[POS_W-1:0];
                end
            end else begin
                n_anchor = w_anchor_inc;
            end
        end
    end

    // (v - zp) * scale, Q5.12, saturated to 18 bits
    assign w_diff = 9'(i_elem_value) - 9'(i_cfg.zero_point);
    assign w_prod = w_diff * $signed({1'b0, i_cfg.scale_q});

    always_comb begin
        if (w_prod > 26'sd131071) begin
            w_d = 18'sd131071;
        end else if (w_prod < -26'sd131072) begin
            w_d = -18'sd131072;
        end else begin
            w_d = w_prod[17:0];
        end
    end

    // sigmoid: table plus truncated linear interpolation, mirrored for negatives
    assign w_abs    = r_a_d[17] ? 18'(-r_a_d) : 18'(r_a_d);
    assign w_idx    = w_abs[17:10];
    assign w_frac   = w_abs[9:0];
    assign w_lo     = sig_rom({1'b0, w_idx[4:0]});
    assign w_hi     = sig_rom({1'b0, w_idx[4:0]} + 6'd1);
    assign w_interp = (w_hi - w_lo) * w_frac;
    assign w_p      = (w_idx >= 8'd32) ? sig_rom(6'd32) : w_lo + w_interp[25:10];
    assign w_neg    = 17'h10000 - {1'b0, w_p};
    assign w_sig    = r_a_d[17] ? w_neg[15:0] : w_p;

    // class maximum, lower index wins ties
    always_comb begin
        n_best     = r_best;
        n_best_cls = r_best_cls;
        case (r_b_kind)
            KIND_CLS_FIRST: begin
                n_best     = r_b_sig;
                n_best_cls = '0;
            end
            KIND_CLS: begin
                if (r_b_sig > r_best) begin
                    n_best     = r_b_sig;
                    n_best_cls = r_b_cls;
                end
            end
            default: begin
                n_best     = r_best;
                n_best_cls = r_best_cls;
            end
        endcase
    end

    assign w_score_full = r_c_obj * r_c_best;
    assign w_score      = w_score_full[31:16];

    assign o_q_push.push       = r_c_valid && !r_c_skip && (w_score >= SCORE_MIN);
    assign o_q_push.job.sx     = r_c_box[0];
    assign o_q_push.job.sy     = r_c_box[1];
    assign o_q_push.job.sw     = r_c_box[2];
    assign o_q_push.job.sh     = r_c_box[3];
    assign o_q_push.job.col    = 7'(r_c_col);
    assign o_q_push.job.row    = 7'(r_c_row);
    assign o_q_push.job.anchor = r_c_anchor;
    assign o_q_push.job.score  = w_score;
    assign o_q_push.job.cls    = r_c_cls;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chan    <= '0;
            r_anchor  <= '0;
            r_col     <= '0;
            r_row     <= '0;
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_skip    <= 1'b0;
        end else begin
            if (w_accept) begin
                r_chan   <= n_chan;
                r_anchor <= n_anchor;
                r_col    <= n_col;
                r_row    <= n_row;
            end
            r_a_valid <= w_accept;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid && r_b_last;
            if (r_b_valid && r_b_kind == KIND_OBJ) begin
                r_skip <= r_b_below;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_a_d       <= w_d;
            r_a_kind    <= w_kind;
            r_a_box_idx <= w_chan[1:0];
            r_a_cls     <= 7'(w_chan) - 7'd5;
            r_a_last    <= w_last;
            r_a_below   <= (i_elem_value < i_cfg.raw_threshold);
            r_a_anchor  <= w_anchor;
            r_a_col     <= w_col;
            r_a_row     <= w_row;
        end
        r_b_sig     <= w_sig;
        r_b_kind    <= r_a_kind;
        r_b_box_idx <= r_a_box_idx;
        r_b_cls     <= r_a_cls;
        r_b_last    <= r_a_valid && r_a_last;
        r_b_below   <= r_a_below;
        r_b_anchor  <= r_a_anchor;
        r_b_col     <= r_a_col;
        r_b_row     <= r_a_row;

        if (r_b_valid) begin
            case (r_b_kind)
                KIND_BOX: r_box[r_b_box_idx] <= r_b_sig;
                KIND_OBJ: r_obj <= r_b_sig;
                default:  r_obj <= r_obj;
            endcase
            r_best     <= n_best;
            r_best_cls <= n_best_cls;
        end

        if (r_b_valid && r_b_last) begin
            r_c_box[0] <= r_box[0];
            r_c_box[1] <= r_box[1];
            r_c_box[2] <= r_box[2];
            r_c_box[3] <= r_box[3];
            r_c_obj    <= r_obj;
            r_c_best   <= n_best;
            r_c_cls    <= n_best_cls;
            r_c_skip   <= r_skip;
            r_c_anchor <= r_b_anchor;
            r_c_col    <= r_b_col;
            r_c_row    <= r_b_row;
        end
    end

    // a vector spans at least six elements: one vector end in the pipe at a time
    a_one_end_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && r_a_last) |-> !r_b_last && !r_c_valid)
        else $error("two vector ends in flight");

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_last) |-> !r_b_last && !r_c_valid)
        else $error("vector end accepted while another is pending");

endmodule

[src/ygd_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ygd_queue
// Short FIFO of box jobs between the intake and the geometry unit.
// ----------------------------------------------------------------------------
module ygd_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ygd_pkg::t_q_push    i_push,
    input  logic                i_pop,
    output ygd_pkg::t_q_status  o_status,
    output ygd_pkg::t_box_job   o_job
);
    import ygd_pkg::*;

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_box_job         r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    logic             w_do_pop;

    assign w_do_pop           = i_pop && (r_count != '0);
    assign o_status.not_empty = (r_count != '0);
    // room for one more vector end besides anything already accepted
    assign o_status.has_room  = (r_count <= CNT_W'(Q_DEPTH - 2));
    assign o_job              = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push.push && !w_do_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push.push && w_do_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wr_ptr] <= i_push.job;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.push |-> (r_count != CNT_W'(Q_DEPTH)) || i_pop)
        else $error("box queue overflow");

endmodule

[src/ygd_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ygd_back
// Box geometry: center, half extents, edges in Q12.4 with saturation, and
// the output register toward the result stream.
// ----------------------------------------------------------------------------
module ygd_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  ygd_pkg::t_cfg                     i_cfg,
    input  ygd_pkg::t_q_status                i_q_status,
    input  ygd_pkg::t_box_job                 i_q_job,
    output logic                              o_q_pop,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [ygd_pkg::OUT_DATA_W-1:0]    o_out_data
);
    import ygd_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SCALE,
        ST_SUM,
        ST_SAT
    } t_state;

    t_state                  r_state;
    t_box_job                r_job;
    logic [8:0]              r_aw;
    logic [8:0]              r_ah;
    logic [6:0]              r_st;
    logic signed [31:0]      r_cx_p;
    logic signed [31:0]      r_cy_p;
    logic [31:0]             r_sqw;
    logic [31:0]             r_sqh;
    logic [41:0]             r_hw;
    logic [41:0]             r_hh;
    logic signed [47:0]      r_left;
    logic signed [47:0]      r_top;
    logic signed [47:0]      r_right;
    logic signed [47:0]      r_bottom;
    logic                    r_out_valid;
    logic [OUT_DATA_W-1:0]   r_out_data;

    logic [8:0]              w_aw;
    logic [8:0]              w_ah;
    logic signed [24:0]      w_tx;
    logic signed [24:0]      w_ty;
    logic signed [31:0]      w_cx_p;
    logic signed [31:0]      w_cy_p;
    logic [40:0]             w_hw_p;
    logic [40:0]             w_hh_p;
    logic signed [47:0]      w_cx;
    logic signed [47:0]      w_cy;
    logic signed [47:0]      w_hw;
    logic signed [47:0]      w_hh;
    logic                    w_load;

    // floor from 2^-32 pixel to Q12.4, saturated
    function automatic logic [15:0] sat_q12_4(input logic signed [47:0] v);
        logic signed [19:0] q;
        logic [15:0]        r;
        q = v[47:28];
        if (q > 20'sd32767) begin
            r = 16'h7FFF;
        end else if (q < -20'sd32768) begin
            r = 16'h8000;
        end else begin
            r = q[15:0];
        end
        return r;
    endfunction

    assign o_q_pop = (r_state == ST_IDLE) && i_q_status.not_empty;

    always_comb begin
        case (i_q_job.anchor)
            2'd0: begin
                w_aw = i_cfg.anchor_widths[8:0];
                w_ah = i_cfg.anchor_heights[8:0];
            end
            2'd1: begin
                w_aw = i_cfg.anchor_widths[17:9];
                w_ah = i_cfg.anchor_heights[17:9];
            end
            2'd2: begin
                w_aw = i_cfg.anchor_widths[26:18];
                w_ah = i_cfg.anchor_heights[26:18];
            end
            default: begin
                w_aw = '0;
                w_ah = '0;
            end
        endcase
    end

    // 2*s - 0.5 + cell, in Q16
    assign w_tx   = $signed({2'b00, r_job.col, 16'h0000}) + $signed({8'h00, r_job.sx, 1'b0})
                  - 25'sd32768;
    assign w_ty   = $signed({2'b00, r_job.row, 16'h0000}) + $signed({8'h00, r_job.sy, 1'b0})
                  - 25'sd32768;
    assign w_cx_p = w_tx * $signed({1'b0, r_st});
    assign w_cy_p = w_ty * $signed({1'b0, r_st});
    assign w_hw_p = r_sqw * r_aw;
    assign w_hh_p = r_sqh * r_ah;

    assign w_cx = {r_cx_p, 16'h0000};
    assign w_cy = {r_cy_p, 16'h0000};
    assign w_hw = $signed({6'b000000, r_hw});
    assign w_hh = $signed({6'b000000, r_hh});

    assign w_load = (r_state == ST_SAT) && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (o_q_pop) begin
                        r_job   <= i_q_job;
                        r_aw    <= w_aw;
                        r_ah    <= w_ah;
                        r_st    <= i_cfg.cell_stride;
                        r_state <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    r_cx_p  <= w_cx_p;
                    r_cy_p  <= w_cy_p;
                    r_sqw   <= r_job.sw * r_job.sw;
                    r_sqh   <= r_job.sh * r_job.sh;
                    r_state <= ST_SCALE;
                end
                ST_SCALE: begin
                    r_hw    <= {w_hw_p, 1'b0};
                    r_hh    <= {w_hh_p, 1'b0};
                    r_state <= ST_SUM;
                end
                ST_SUM: begin
                    r_left   <= w_cx - w_hw;
                    r_top    <= w_cy - w_hh;
                    r_right  <= w_cx + w_hw;
                    r_bottom <= w_cy + w_hh;
                    r_state  <= ST_SAT;
                end
                ST_SAT: begin
                    if (w_load) begin
                        r_out_data <= {1'b0, r_job.anchor, r_job.col, r_job.row, r_job.cls,
                                       r_job.score, sat_q12_4(r_bottom), sat_q12_4(r_right),
                                       sat_q12_4(r_top), sat_q12_4(r_left)};
                        r_state    <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_sat_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SAT && !r_out_valid) |=> r_out_valid && r_state == ST_IDLE)
        else $error("finished box not loaded into empty output register");

endmodule
